// ===== design/sbv_pkg.sv =====
// ============================================================================
// sbv_pkg: shared types and constants for the schema block checker
// Holds status codes, register indexes and the front-to-back word format.
// ============================================================================
package sbv_pkg;

    localparam int MaxNameBytes = 64;
    localparam int NameIdxW     = $clog2(MaxNameBytes);
    localparam logic [16:0] MaxFields = 17'd65536;

    // Status codes of a result.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BOUNDS = 3'd1;
    localparam logic [2:0] ST_LIMIT  = 3'd2;
    localparam logic [2:0] ST_TRUNC  = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;
    localparam logic [2:0] ST_STRING = 3'd5;
    localparam logic [2:0] ST_SCHEMA = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_AVAIL = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    // One accepted byte as it passes from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [16:0] fields_checked;
        logic [31:0] error_offset;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== design/sbv_front.sv =====
// ============================================================================
// sbv_front: input side and byte queue
// Accepts stream transactions, drops idle bytes and queues the rest.
// ============================================================================
module sbv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // data_byte[7:0]
    input  logic           s_axis_tuser,   // first
    input  logic           i_busy,         // back part is inside a block
    input  logic           i_done,         // back part ends the block this cycle
    output sbv_pkg::t_item o_item,
    output logic           o_valid,
    input  logic           i_take
);
    import sbv_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = 2;

    t_item            r_mem [Depth];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [PtrW:0]    r_cnt;
    logic             r_open;   // a block is open ahead of the back part
    logic             n_open;
    logic             acc, keep, pop;

    assign s_axis_tready = (r_cnt != (PtrW+1)'(Depth));
    assign acc  = s_axis_tvalid && s_axis_tready;
    // Bytes with first clear while no block is open are dropped here.
    assign keep = acc && (s_axis_tuser || r_open);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign pop = o_valid && i_take;

    // Track whether queued bytes belong to a live block. Queued bytes after a
    // block's end are still dropped by the back part, which holds the truth.
    always_comb begin
        n_open = r_open;
        if (i_done && r_cnt == '0 && !keep) n_open = 1'b0;
        if (!i_busy && r_cnt == '0 && !keep) n_open = 1'b0;
        if (keep) n_open = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0; r_open <= 1'b0;
        end else begin
            r_open <= n_open;
            if (keep) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(keep) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) r_mem[r_wr] <= '{data_byte: s_axis_tdata, first: s_axis_tuser};
    end

endmodule

// ===== design/sbv_back.sv =====
// ============================================================================
// sbv_back: schema parser and checker
// Walks the block one byte per cycle while its result register is free and gives one result per block.
// ============================================================================
module sbv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbv_pkg::t_item   i_item,
    input  logic             i_valid,
    output logic             o_take,
    output logic             o_busy,
    output logic             o_done,
    input  logic [31:0]      i_start,
    input  logic [31:0]      i_size,
    input  logic [31:0]      i_avail,
    input  logic [6:0]       i_limit,
    output sbv_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);
    import sbv_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_COUNT, PH_ID, PH_LEN, PH_NAME, PH_TYPE, PH_REQ
    } t_phase;
    typedef enum logic [1:0] {CMP_EQ, CMP_LT, CMP_GT} t_cmp;

    t_phase       r_ph, n_ph;
    logic [31:0]  r_pos, n_pos, r_acc, n_acc, r_last, n_last;
    logic [2:0]   r_vb, n_vb;
    logic [16:0]  r_left, n_left, r_done, n_done;
    logic         r_have, n_have;
    logic [6:0]   r_nlen, n_nlen, r_nidx, n_nidx, r_plen, n_plen;
    t_cmp         r_cmp, n_cmp;
    logic [1:0]   r_up, n_up;
    logic         r_bad, n_bad;
    logic [7:0]   r_prev [MaxNameBytes];
    logic [7:0]   r_old_b;
    logic [NameIdxW-1:0] rd_addr;
    t_result      r_res;
    logic         r_rv, n_rv;

    logic         fire, emit;
    logic [2:0]   e_st;
    logic [32:0]  e_rel;
    logic         e_abs;
    logic [7:0]   b;
    logic [32:0]  p1, nend;
    logic [31:0]  shp, v;
    logic [6:0]   lim;
    logic         wr_name;
    logic [1:0]   u_up;
    logic         u_bad, name_end;

    assign o_take = !r_rv || i_res_ready;
    assign fire   = i_valid && o_take;
    assign o_busy = (r_ph != PH_IDLE);
    assign o_done = fire && emit;
    assign o_res = r_res;
    assign o_res_valid = r_rv;
    assign n_rv = (fire && emit) ? 1'b1 : (i_res_ready ? 1'b0 : r_rv);
    assign b  = i_item.data_byte;
    assign lim = (i_limit > 7'(MaxNameBytes)) ? 7'(MaxNameBytes) : i_limit;

    // The stored name byte for the next name index is read into a register ahead of use,
    // so r_old_b always holds the entry at r_nidx.
    assign rd_addr = (!i_rst_n) ? '0 :
                     (fire ? n_nidx[NameIdxW-1:0] : r_nidx[NameIdxW-1:0]);

    // Shift of one varint group; a fifth byte keeps only its low four bits.
    always_comb begin
        unique case (i_item.first ? 3'd0 : r_vb)
            3'd0: shp = {25'd0, b[6:0]};
            3'd1: shp = {18'd0, b[6:0], 7'd0};
            3'd2: shp = {11'd0, b[6:0], 14'd0};
            3'd3: shp = {4'd0, b[6:0], 21'd0};
            default: shp = {b[3:0], 28'd0};
        endcase
    end

    // Structural UTF-8 step.
    always_comb begin
        u_up = r_up; u_bad = r_bad;
        if (r_up != 2'd0) begin
            if (b[7:6] != 2'b10) u_bad = 1'b1;
            u_up = r_up - 2'd1;
        end else if (!b[7]) begin
            u_up = 2'd0;
        end else if (b[7:5] == 3'b110) u_up = 2'd1;
        else if (b[7:4] == 4'b1110) u_up = 2'd2;
        else if (b[7:3] == 5'b11110) u_up = 2'd3;
        else u_bad = 1'b1;
    end

    function automatic logic type_ok(input logic [7:0] t);
        unique case (t)
            8'h00, 8'h01, 8'h02, 8'h10, 8'h11, 8'h12,
            8'h20, 8'h21, 8'h22, 8'h30, 8'h40: type_ok = 1'b1;
            default: type_ok = 1'b0;
        endcase
    endfunction

    // Parser next state.
    always_comb begin
        logic [31:0] pp;
        logic        nm_fail;
        logic [2:0]  nm_st;
        n_ph = r_ph; n_pos = r_pos; n_acc = r_acc; n_vb = r_vb; n_left = r_left;
        n_done = r_done; n_last = r_last; n_have = r_have; n_nlen = r_nlen;
        n_nidx = r_nidx; n_plen = r_plen; n_cmp = r_cmp; n_up = r_up; n_bad = r_bad;
        emit = 1'b0; e_st = ST_OK; e_rel = '0; e_abs = 1'b0; wr_name = 1'b0;
        v = r_acc | shp; nm_fail = 1'b0; nm_st = ST_OK; name_end = 1'b0;
        pp = r_pos;
        if (i_item.first) begin
            n_ph = PH_COUNT; pp = '0; n_acc = '0; n_vb = '0; n_left = '0;
            n_done = '0; n_last = '0; n_have = 1'b0; n_plen = '0;
            v = shp & 32'h7F;
        end
        p1 = {1'b0, pp} + 33'd1;
        nend = p1 + {1'b0, v};
        n_pos = pp;
        if (i_item.first && i_avail == '0) begin
            emit = 1'b1; e_st = ST_BOUNDS;
        end else if (!i_item.first && r_ph == PH_IDLE) begin
            n_ph = PH_IDLE;
        end else begin
            priority case (n_ph)
                PH_COUNT, PH_ID, PH_LEN: begin
                    if (b[7]) begin
                        n_acc = v; n_vb = (i_item.first ? 3'd0 : r_vb) + 3'd1;
                        if (n_vb >= 3'd5 || p1 >= {1'b0, i_avail}) begin
                            emit = 1'b1; e_st = ST_BOUNDS;
                            e_rel = (n_ph == PH_COUNT) ? 33'd0 : p1;
                        end else n_pos = p1[31:0];
                    end else begin
                        n_acc = '0; n_vb = '0;
                        if (n_ph == PH_COUNT) begin
                            if (v > {15'd0, MaxFields}) begin
                                emit = 1'b1; e_st = ST_LIMIT;
                            end else if (v == '0) begin
                                emit = 1'b1; e_st = ST_OK; e_abs = 1'b1;
                            end else begin
                                n_left = v[16:0];
                                if (p1 >= {1'b0, i_size}) begin
                                    emit = 1'b1; e_st = ST_TRUNC; e_rel = {1'b0, i_size};
                                end else if (p1 >= {1'b0, i_avail}) begin
                                    emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                                end else begin
                                    n_ph = PH_ID; n_pos = p1[31:0];
                                end
                            end
                        end else if (n_ph == PH_ID) begin
                            if (r_have && v < r_last) begin
                                emit = 1'b1; e_st = ST_ORDER; e_rel = p1;
                            end else begin
                                n_last = v;
                                if (p1 >= {1'b0, i_avail}) begin
                                    emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                                end else begin
                                    n_ph = PH_LEN; n_pos = p1[31:0];
                                end
                            end
                        end else begin
                            if (v > {25'd0, lim}) begin
                                emit = 1'b1; e_st = ST_LIMIT; e_rel = p1;
                            end else if (nend > {1'b0, i_avail}) begin
                                emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                            end else begin
                                n_nlen = v[6:0]; n_nidx = '0; n_cmp = CMP_EQ;
                                n_up = '0; n_bad = 1'b0; n_pos = p1[31:0];
                                if (v == '0) begin
                                    // An empty name never rises above a previous one.
                                    name_end = 1'b1;
                                    if (r_have) begin
                                        nm_fail = 1'b1; nm_st = ST_SCHEMA;
                                    end
                                end else n_ph = PH_NAME;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    n_up = u_up; n_bad = u_bad; wr_name = 1'b1;
                    if (r_cmp == CMP_EQ && r_nidx < r_plen) begin
                        if (r_old_b < b) n_cmp = CMP_LT;
                        else if (r_old_b > b) n_cmp = CMP_GT;
                    end
                    n_nidx = r_nidx + 7'd1;
                    n_pos = p1[31:0];
                    if (n_nidx >= r_nlen) begin
                        name_end = 1'b1;
                        if (u_bad || u_up != 2'd0) begin
                            nm_fail = 1'b1; nm_st = ST_STRING;
                        end else if (r_have && (n_cmp == CMP_GT ||
                                     (n_cmp == CMP_EQ && r_plen >= r_nlen))) begin
                            nm_fail = 1'b1; nm_st = ST_SCHEMA;
                        end
                    end
                end
                PH_TYPE: begin
                    if (!type_ok(b)) begin
                        emit = 1'b1; e_st = ST_SCHEMA; e_rel = {1'b0, pp};
                    end else if (p1 >= {1'b0, i_avail}) begin
                        emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                    end else begin
                        n_ph = PH_REQ; n_pos = p1[31:0];
                    end
                end
                PH_REQ: begin
                    if (b > 8'd1) begin
                        emit = 1'b1; e_st = ST_SCHEMA; e_rel = {1'b0, pp};
                    end else begin
                        n_have = 1'b1; n_plen = r_nlen;
                        n_done = r_done + 17'd1; n_left = r_left - 17'd1;
                        if (n_left == '0) begin
                            emit = 1'b1; e_st = ST_OK; e_abs = 1'b1;
                        end else if (p1 >= {1'b0, i_size}) begin
                            emit = 1'b1; e_st = ST_TRUNC; e_rel = {1'b0, i_size};
                        end else if (p1 >= {1'b0, i_avail}) begin
                            emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                        end else begin
                            n_ph = PH_ID; n_pos = p1[31:0];
                        end
                    end
                end
                default: n_ph = PH_IDLE;
            endcase
            // Shared end-of-name checks.
            if (name_end) begin
                if (nm_fail) begin
                    emit = 1'b1; e_st = nm_st; e_rel = p1;
                end else if (p1 >= {1'b0, i_avail}) begin
                    emit = 1'b1; e_st = ST_BOUNDS; e_rel = p1;
                end else begin
                    n_ph = PH_TYPE; n_pos = p1[31:0];
                end
            end
        end
        if (emit) n_ph = PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_rv <= 1'b0; r_pos <= '0; r_acc <= '0; r_vb <= '0;
            r_left <= '0; r_done <= '0; r_last <= '0; r_have <= 1'b0;
            r_nlen <= '0; r_nidx <= '0; r_plen <= '0; r_cmp <= CMP_EQ;
            r_up <= '0; r_bad <= 1'b0;
        end else begin
            r_rv <= n_rv;
            if (fire) begin
                r_ph <= n_ph; r_pos <= n_pos; r_acc <= n_acc; r_vb <= n_vb;
                r_left <= n_left; r_done <= n_done; r_last <= n_last;
                r_have <= n_have; r_nlen <= n_nlen; r_nidx <= n_nidx;
                r_plen <= n_plen; r_cmp <= n_cmp; r_up <= n_up; r_bad <= n_bad;
            end
        end
    end

    // Result register and stored previous name with a registered read.
    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_res.status <= e_st;
            r_res.error_offset <= e_abs ? 32'd0 : (i_start + e_rel[31:0]);
            r_res.fields_checked <= n_done;
        end
        if (fire && wr_name)
            r_prev[r_nidx[NameIdxW-1:0]] <= b;
        r_old_b <= r_prev[rd_addr];
    end

endmodule

// ===== design/schema_block_validator_top.sv =====
// ============================================================================
// schema_block_validator_top: streaming schema block checker
// Checks a schema block byte by byte and reports one status per block.
// ============================================================================
//  Channel   | Direction | Payload
//  s_axis    | in        | tdata = data_byte, tuser = first
//  m_axis    | out       | tdata = status, error_offset, fields_checked
//  cfg       | in        | index 0..3, 32-bit data
//
//  One byte per cycle is sustained; the parser consumes a queued byte each
//  cycle its result register is free. A result is registered in the parser
//  once the input transaction that ends or breaks the block has passed the
//  byte queue. A four-entry byte queue decouples the input from output
//  stalls. Reset is synchronous and active low; no clearing pass is needed.
module schema_block_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[2:0], error_offset[34:3], fields_checked[51:35]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sbv_pkg::*;

    t_item       item;
    t_result     res;
    logic        q_valid, take, busy, done;
    logic [31:0] r_start, r_size, r_avail;
    logic [6:0]  r_limit;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_size <= '0; r_avail <= '0; r_limit <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START: r_start <= i_cfg_data;
                REG_SIZE:  r_size  <= i_cfg_data;
                REG_AVAIL: r_avail <= i_cfg_data;
                REG_LIMIT: r_limit <= i_cfg_data[6:0];
                default:   r_start <= r_start;
            endcase
        end
    end

    sbv_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .i_busy(busy), .i_done(done), .o_item(item),
        .o_valid(q_valid), .i_take(take)
    );

    sbv_back u_back (
        .i_clk, .i_rst_n, .i_item(item), .i_valid(q_valid), .o_take(take),
        .o_busy(busy), .o_done(done), .i_start(r_start), .i_size(r_size),
        .i_avail(r_avail), .i_limit(r_limit), .o_res(res),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, res.fields_checked, res.error_offset, res.status};

endmodule
